@@ sv/char_lcd_dirty_cell_updater_unit_macros.svh @@
// Assertion macros for the character LCD dirty-cell updater checker.
// No dependencies; included by the checker file.
`ifndef CHAR_LCD_DIRTY_CELL_UPDATER_UNIT_MACROS_SVH
`define CHAR_LCD_DIRTY_CELL_UPDATER_UNIT_MACROS_SVH

// General property checked on every clock edge unless the disable term is high.
`define CLDU_ASSERT(label, dis, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (dis) prop) else $error(msg);

// A stalled output beat keeps its valid and the given signal.
`define CLDU_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

@@ sv/cldu_pkg.sv @@
// Package of the character LCD dirty-cell updater: screen geometry, operation
// codes, controller command bytes and the job record passed front to back.
package cldu_pkg;

    localparam int ROWS        = 2;
    localparam int COLUMNS     = 16;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_CELL  = 2'd0;
    localparam logic [1:0] OP_INIT  = 2'd1;
    localparam logic [1:0] OP_BLINK = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_BLINK_ON     = 8'h0F;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_SET_ADDRESS  = 8'h80;
    localparam logic [7:0] ROW1_OFFSET      = 8'h40;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr;
        logic       wr;
        logic [7:0] addr;
        logic [7:0] chr;
        logic       blink;
    } t_job;

endpackage

@@ sv/cldu_front.sv @@
// Front end: accepts items, tracks the shadow screen and screen id, and turns
// each item that needs bus beats into one job record. Depends on cldu_pkg.
module cldu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    input  logic          i_row,
    input  logic [3:0]    i_column,
    input  logic [7:0]    i_character,
    input  logic [7:0]    i_screen_id,
    input  logic          i_frame_start,
    input  logic          i_blink_on,
    input  logic          i_full,
    output logic          o_push,
    output cldu_pkg::t_job o_job
);
    import cldu_pkg::*;

    logic [7:0]       r_cells [CELLS];
    logic [CELLS-1:0] r_valid;
    logic [CELLS-1:0] n_valid;
    logic [7:0]       r_prev_screen;
    logic             r_has_drawn;

    logic              accept;
    logic              is_cell;
    logic              clr;
    logic              in_range;
    logic [CELL_W-1:0] idx;
    logic [7:0]        shadow;
    logic              wr;
    logic [7:0]        addr;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign is_cell  = (i_op == OP_CELL);
    assign clr      = is_cell && i_frame_start && (!r_has_drawn || i_screen_id != r_prev_screen);
    assign in_range = (int'(i_row) < ROWS) && (int'(i_column) < COLUMNS);
    assign idx      = CELL_W'(CELL_W'(i_row) * CELL_W'(COLUMNS)) + CELL_W'(i_column);

    always_comb begin
        shadow = CHAR_SPACE;
        if (in_range && !clr && r_valid[idx]) begin
            shadow = r_cells[idx];
        end
    end

    assign wr   = is_cell && in_range && (shadow != i_character);
    assign addr = CMD_SET_ADDRESS | ((i_row ? ROW1_OFFSET : 8'h00) + {4'b0000, i_column});

    assign o_push = accept && (!is_cell || clr || wr);
    always_comb begin
        o_job.kind  = i_op;
        o_job.clr   = clr;
        o_job.wr    = wr;
        o_job.addr  = addr;
        o_job.chr   = i_character;
        o_job.blink = i_blink_on;
    end

    always_comb begin
        n_valid = r_valid;
        if (clr || (i_op == OP_CLEAR)) begin
            n_valid = '0;
        end
        if (wr) begin
            n_valid[idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_prev_screen <= 8'h00;
            r_has_drawn   <= 1'b0;
        end else if (accept) begin
            r_valid <= n_valid;
            if (is_cell && i_frame_start) begin
                r_prev_screen <= i_screen_id;
                r_has_drawn   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr) begin
            r_cells[idx] <= i_character;
        end
    end

endmodule

@@ sv/cldu_queue.sv @@
// Short job queue between the front end and the bus writer.
// Depends on cldu_pkg for the job record and the depth.
module cldu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cldu_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cldu_pkg::t_job o_job
);
    import cldu_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

@@ sv/cldu_back.sv @@
// Bus writer: steps through the beats of the job at the queue head and holds
// each beat in an output register. Depends on cldu_pkg.
module cldu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  cldu_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_register_select,
    output logic [7:0]     o_bus_byte,
    output logic           o_long_wait,
    output logic           o_last
);
    import cldu_pkg::*;

    logic [2:0] r_step;
    logic       r_o_valid;
    logic       r_rs;
    logic [7:0] r_byte;
    logic       r_long;
    logic       r_last;

    logic [2:0] beats;
    logic [2:0] k;
    logic       rs;
    logic [7:0] byte_val;
    logic       last;
    logic       load;

    always_comb begin
        beats    = 3'd1;
        rs       = 1'b0;
        byte_val = CMD_CLEAR;
        k        = r_step - {2'b00, i_job.clr};
        unique case (i_job.kind)
            OP_CELL: begin
                beats = {2'b00, i_job.clr} + {1'b0, i_job.wr, 1'b0};
                if (i_job.clr && r_step == 3'd0) begin
                    byte_val = CMD_CLEAR;
                end else if (k == 3'd0) begin
                    byte_val = i_job.addr;
                end else begin
                    rs       = 1'b1;
                    byte_val = i_job.chr;
                end
            end
            OP_INIT: begin
                beats = 3'd5;
                if (r_step < 3'd3) begin
                    byte_val = CMD_FUNCTION_SET;
                end else if (r_step == 3'd3) begin
                    byte_val = CMD_DISPLAY_ON;
                end else begin
                    byte_val = CMD_CLEAR;
                end
            end
            OP_BLINK: begin
                byte_val = i_job.blink ? CMD_BLINK_ON : CMD_DISPLAY_ON;
            end
            default: begin
                byte_val = CMD_CLEAR;
            end
        endcase
    end

    assign last  = (r_step == beats - 3'd1);
    assign load  = i_job_valid && (!r_o_valid || i_ready);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step    <= last ? 3'd0 : r_step + 3'd1;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rs   <= rs;
            r_byte <= byte_val;
            r_long <= !rs && (byte_val == CMD_CLEAR);
            r_last <= last;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_register_select = r_rs;
    assign o_bus_byte        = r_byte;
    assign o_long_wait       = r_long;
    assign o_last            = r_last;

endmodule

@@ sv/char_lcd_dirty_cell_updater_unit.sv @@
// Character LCD dirty-cell updater: front end, job queue and bus writer.
// Items are taken every cycle while the two-entry job queue has room.
// Throughput: one bus beat per cycle from the bus writer while i_ready holds; a
// changed cell takes two or three beats, init five, blink and clear one, an unchanged
// cell none or a clear beat. Beats go through the job queue and output register.
// Synchronous active-low reset blanks the shadow screen and empties the queue at once.
module char_lcd_dirty_cell_updater_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic       i_row,
    input  logic [3:0] i_column,
    input  logic [7:0] i_character,
    input  logic [7:0] i_screen_id,
    input  logic       i_frame_start,
    input  logic       i_blink_on,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_register_select,
    output logic [7:0] o_bus_byte,
    output logic       o_long_wait,
    output logic       o_last
);
    import cldu_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_job push_job;
    t_job head_job;

    cldu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_character  (i_character),
        .i_screen_id  (i_screen_id),
        .i_frame_start(i_frame_start),
        .i_blink_on   (i_blink_on),
        .i_full       (full),
        .o_push       (push),
        .o_job        (push_job)
    );

    cldu_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(head_valid),
        .o_job  (head_job)
    );

    cldu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (head_valid),
        .i_job            (head_job),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_register_select(o_register_select),
        .o_bus_byte       (o_bus_byte),
        .o_long_wait      (o_long_wait),
        .o_last           (o_last)
    );

endmodule

@@ sv/cldu_checker.sv @@
// Port-level checker for the character LCD dirty-cell updater, bound to the top.
// Depends on cldu_pkg and char_lcd_dirty_cell_updater_unit_macros.svh.
`include "char_lcd_dirty_cell_updater_unit_macros.svh"

module cldu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_register_select,
    input logic [7:0] o_bus_byte,
    input logic       o_long_wait,
    input logic       o_last
);
    import cldu_pkg::*;

    logic clear_beat;
    logic addr_beat;

    assign clear_beat = !o_register_select && (o_bus_byte == CMD_CLEAR);
    assign addr_beat  = !o_register_select && o_bus_byte[7];

    `CLDU_ASSERT(a_reset_idle, 1'b0, !i_rst_n |=> !o_valid, "output valid after reset")
    `CLDU_ASSERT(a_long_wait, !i_rst_n, o_valid |-> (o_long_wait == clear_beat), "long wait")
    `CLDU_ASSERT(a_data_last, !i_rst_n, (o_valid && o_register_select) |-> o_last, "data not last")
    `CLDU_ASSERT(a_addr_not_last, !i_rst_n, (o_valid && addr_beat) |-> !o_last, "lone address")
    `CLDU_ASSERT_HOLD(a_hold, o_valid, i_ready, o_bus_byte, "stalled beat changed")

endmodule

bind char_lcd_dirty_cell_updater_unit cldu_checker u_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the character LCD dirty-cell updater.
// A directed table followed by random frames and commands, with every bus beat checked
// against the table or a shadow-screen predictor. Depends on cldu_pkg and the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cldu_pkg::*;

    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS  = 160;
    localparam logic [8:0] NO_BEAT = 9'h000;

    typedef struct packed {
        logic [1:0] op;
        logic       row;
        logic [3:0] col;
        logic [7:0] chr;
        logic [7:0] scr;
        logic       fs;
        logic       blink;
    } lcd_item_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] bus;
        logic       lw;
        logic       last;
    } lcd_beat_t;

    typedef struct packed {
        lcd_item_t        it;
        logic             typed;
        logic [2:0]       n;
        logic [0:4][8:0]  w;
    } dir_row_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_op = '0;
    logic       i_row = 1'b0;
    logic [3:0] i_column = '0;
    logic [7:0] i_character = '0;
    logic [7:0] i_screen_id = '0;
    logic       i_frame_start = 1'b0;
    logic       i_blink_on = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic       o_register_select;
    logic [7:0] o_bus_byte;
    logic       o_long_wait;
    logic       o_last;

    lcd_beat_t  bus_expect_q[$];
    logic [7:0] shadow_screen [CELLS];
    logic [7:0] last_screen;
    logic       drawn;
    int         mismatches = 0;
    int         items_sent = 0;
    logic       calm = 1'b0;

    char_lcd_dirty_cell_updater_unit uut (.*);

    always #6 i_clk = ~i_clk;

    function automatic lcd_item_t mk_it(logic [1:0] op, logic row, logic [3:0] col,
                                        logic [7:0] chr, logic [7:0] scr, logic fs,
                                        logic blink);
        return '{op: op, row: row, col: col, chr: chr, scr: scr, fs: fs, blink: blink};
    endfunction

    function automatic dir_row_t typed_row(lcd_item_t it, int n, logic [0:4][8:0] w);
        return '{it: it, typed: 1'b1, n: 3'(n), w: w};
    endfunction

    function automatic dir_row_t model_row(lcd_item_t it);
        return '{it: it, typed: 1'b0, n: 3'd0, w: '0};
    endfunction

    function automatic logic [8:0] cw(logic [7:0] b);
        return {1'b0, b};
    endfunction

    function automatic logic [8:0] dw(logic [7:0] b);
        return {1'b1, b};
    endfunction

    function automatic lcd_beat_t mk_beat(logic rs, logic [7:0] b);
        return '{rs: rs, bus: b, lw: (rs == 1'b0 && b == CMD_CLEAR), last: 1'b0};
    endfunction

    function automatic void blank_shadow();
        for (int c = 0; c < CELLS; c++) begin
            shadow_screen[c] = CHAR_SPACE;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t bus beat field %s: expected %02h, actual %02h", $time, name,
                     want, got);
            mismatches++;
        end
    endfunction

    task automatic lcd_predict(input lcd_item_t it, output int n,
                               output lcd_beat_t [0:4] burst);
        int idx;
        logic [7:0] addr;
        n = 0;
        burst = '0;
        case (it.op)
            OP_CELL: begin
                if (it.fs) begin
                    if (!drawn || it.scr != last_screen) begin
                        burst[n] = mk_beat(1'b0, CMD_CLEAR);
                        n++;
                        blank_shadow();
                    end
                    last_screen = it.scr;
                    drawn = 1'b1;
                end
                if (it.row < ROWS && it.col < COLUMNS) begin
                    idx = it.row * COLUMNS + it.col;
                    if (shadow_screen[idx] != it.chr) begin
                        addr = (it.row ? ROW1_OFFSET : 8'h00) + 8'(it.col);
                        burst[n] = mk_beat(1'b0, CMD_SET_ADDRESS | addr);
                        n++;
                        burst[n] = mk_beat(1'b1, it.chr);
                        n++;
                        shadow_screen[idx] = it.chr;
                    end
                end
            end
            OP_INIT: begin
                burst[0] = mk_beat(1'b0, CMD_FUNCTION_SET);
                burst[1] = mk_beat(1'b0, CMD_FUNCTION_SET);
                burst[2] = mk_beat(1'b0, CMD_FUNCTION_SET);
                burst[3] = mk_beat(1'b0, CMD_DISPLAY_ON);
                burst[4] = mk_beat(1'b0, CMD_CLEAR);
                n = 5;
            end
            OP_BLINK: begin
                burst[0] = mk_beat(1'b0, it.blink ? CMD_BLINK_ON : CMD_DISPLAY_ON);
                n = 1;
            end
            default: begin
                burst[0] = mk_beat(1'b0, CMD_CLEAR);
                n = 1;
                blank_shadow();
            end
        endcase
        if (n > 0) begin
            burst[n - 1].last = 1'b1;
        end
    endtask

    task automatic lcd_send_item(input dir_row_t r);
        int n;
        int i;
        lcd_beat_t [0:4] burst;
        while (!calm && $urandom_range(0, 99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= r.it.op;
        i_row         <= r.it.row;
        i_column      <= r.it.col;
        i_character   <= r.it.chr;
        i_screen_id   <= r.it.scr;
        i_frame_start <= r.it.fs;
        i_blink_on    <= r.it.blink;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        lcd_predict(r.it, n, burst);
        if (r.typed) begin
            n = r.n;
            burst = '0;
            for (i = 0; i < n; i++) begin
                burst[i] = mk_beat(r.w[i][8], r.w[i][7:0]);
            end
            if (n > 0) begin
                burst[n - 1].last = 1'b1;
            end
        end
        for (i = 0; i < n; i++) begin
            bus_expect_q.push_back(burst[i]);
        end
        items_sent++;
        calm <= (items_sent >= 70 && items_sent < 110);
    endtask

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge i_clk) begin : bus_monitor
        lcd_beat_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (bus_expect_q.size() == 0) begin
                $display("%0t unexpected bus beat: expected none, actual rs=%0b byte=%02h",
                         $time, o_register_select, o_bus_byte);
                mismatches++;
            end else begin
                want = bus_expect_q.pop_front();
                check_field("register_select", 8'(want.rs), 8'(o_register_select));
                check_field("bus_byte", want.bus, o_bus_byte);
                check_field("long_wait", 8'(want.lw), 8'(o_long_wait));
                check_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    initial begin : stimulus
        dir_row_t   tbl [DIRECTED_ROWS];
        lcd_item_t  it;
        logic [7:0] screens [3];
        logic [7:0] scr;
        logic [7:0] chr;
        logic       broken;
        int         start;
        int         len;
        int         k;
        int         pick;

        blank_shadow();
        last_screen = '0;
        drawn = 1'b0;
        screens = '{8'h00, 8'h5A, 8'hFF};

        tbl[0]  = typed_row(mk_it(OP_BLINK, 0, 0, 8'h00, 8'h00, 0, 0), 1,
                            {cw(CMD_DISPLAY_ON), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[1]  = typed_row(mk_it(OP_BLINK, 0, 0, 8'h00, 8'h00, 0, 1), 1,
                            {cw(CMD_BLINK_ON), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[2]  = typed_row(mk_it(OP_INIT, 0, 0, 8'h00, 8'h00, 0, 0), 5,
                            {cw(CMD_FUNCTION_SET), cw(CMD_FUNCTION_SET), cw(CMD_FUNCTION_SET),
                             cw(CMD_DISPLAY_ON), cw(CMD_CLEAR)});
        tbl[3]  = typed_row(mk_it(OP_CLEAR, 0, 0, 8'h00, 8'h00, 0, 0), 1,
                            {cw(CMD_CLEAR), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[4]  = typed_row(mk_it(OP_CELL, 0, 0, 8'h41, 8'h00, 1, 0), 3,
                            {cw(CMD_CLEAR), cw(CMD_SET_ADDRESS), dw(8'h41), NO_BEAT, NO_BEAT});
        tbl[5]  = typed_row(mk_it(OP_CELL, 1, 15, 8'hFF, 8'h00, 0, 0), 2,
                            {cw(CMD_SET_ADDRESS | (ROW1_OFFSET + 8'd15)), dw(8'hFF),
                             NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[6]  = typed_row(mk_it(OP_CELL, 0, 15, 8'h00, 8'h00, 0, 0), 2,
                            {cw(CMD_SET_ADDRESS | 8'd15), dw(8'h00),
                             NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[7]  = typed_row(mk_it(OP_CELL, 1, 0, CHAR_SPACE, 8'h00, 0, 0), 0, '0);
        tbl[8]  = typed_row(mk_it(OP_CELL, 0, 0, 8'h41, 8'h00, 0, 0), 0, '0);
        tbl[9]  = typed_row(mk_it(OP_CELL, 0, 0, 8'h41, 8'h00, 1, 0), 0, '0);
        tbl[10] = typed_row(mk_it(OP_CELL, 0, 0, 8'h41, 8'hFF, 1, 0), 3,
                            {cw(CMD_CLEAR), cw(CMD_SET_ADDRESS), dw(8'h41), NO_BEAT, NO_BEAT});
        tbl[11] = model_row(mk_it(OP_CELL, 1, 15, 8'hFF, 8'hFF, 0, 0));
        tbl[12] = typed_row(mk_it(OP_CELL, 0, 1, CHAR_SPACE, 8'h00, 1, 0), 1,
                            {cw(CMD_CLEAR), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[13] = model_row(mk_it(OP_CELL, 1, 5, 8'h5A, 8'h00, 0, 0));
        tbl[14] = typed_row(mk_it(OP_CLEAR, 1, 15, 8'hFF, 8'hFF, 1, 1), 1,
                            {cw(CMD_CLEAR), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[15] = typed_row(mk_it(OP_BLINK, 0, 0, 8'h00, 8'h55, 1, 1), 1,
                            {cw(CMD_BLINK_ON), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});
        tbl[16] = typed_row(mk_it(OP_INIT, 0, 0, 8'h00, 8'hAA, 1, 0), 5,
                            {cw(CMD_FUNCTION_SET), cw(CMD_FUNCTION_SET), cw(CMD_FUNCTION_SET),
                             cw(CMD_DISPLAY_ON), cw(CMD_CLEAR)});
        tbl[17] = model_row(mk_it(OP_CELL, 1, 5, 8'h5A, 8'h00, 1, 0));
        tbl[18] = model_row(mk_it(OP_CELL, 1, 5, 8'h5A, 8'h00, 0, 0));
        tbl[19] = model_row(mk_it(OP_CELL, 0, 10, 8'h80, 8'h00, 0, 0));
        tbl[20] = typed_row(mk_it(OP_BLINK, 1, 15, 8'hFF, 8'hFF, 1, 0), 1,
                            {cw(CMD_DISPLAY_ON), NO_BEAT, NO_BEAT, NO_BEAT, NO_BEAT});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            lcd_send_item(tbl[k]);
        end

        // Mostly row-major frames that repaint part of the screen, mixed with raw items.
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                broken = ($urandom_range(0, 9) == 0);
                start = broken ? $urandom_range(1, CELLS - 1) : 0;
                len = $urandom_range(4, 24);
                scr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : screens[$urandom_range(0, 2)];
                for (k = start; k < start + len && k < CELLS; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55) begin
                        chr = shadow_screen[k];
                    end else if (pick < 80) begin
                        chr = 8'h41 + 8'($urandom_range(0, 25));
                    end else begin
                        chr = 8'($urandom_range(0, 255));
                    end
                    it = mk_it(OP_CELL, 1'(k / COLUMNS), 4'(k % COLUMNS), chr, scr,
                               (k == start) && (!broken || $urandom_range(0, 1) == 1),
                               1'($urandom_range(0, 1)));
                    lcd_send_item(model_row(it));
                end
            end else begin
                it = mk_it(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                lcd_send_item(model_row(it));
            end
        end
        i_valid <= 1'b0;

        while (bus_expect_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[char_lcd_dirty_cell_updater_unit] OK");
        end else begin
            $display("[char_lcd_dirty_cell_updater_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[char_lcd_dirty_cell_updater_unit] ERROR");
        $finish;
    end

endmodule
